// ----- rtl/savings_route_heuristic_macros.svh -----
// Assertion macros for the savings route heuristic.
`ifndef SAVINGS_ROUTE_HEURISTIC_MACROS_SVH
`define SAVINGS_ROUTE_HEURISTIC_MACROS_SVH
// same-cycle implication
`define SRH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srh assertion failed");
// next-cycle implication
`define SRH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srh assertion failed");
`endif

// ----- rtl/srh_pkg.sv -----
// Package: types and constants of the savings route heuristic.
package srh_pkg;
  localparam int DEF_MAX_NODES  = 64;
  localparam int DEF_COORD_BITS = 16;
  localparam int COORD_W  = 16;
  localparam int DEMAND_W = 16;
  localparam int COST_W   = 24;
  localparam int CAP_W    = 24;
  localparam logic [CAP_W-1:0]  CAP_RESET = {CAP_W{1'b1}};
  localparam logic [COST_W-1:0] COST_MAX  = {COST_W{1'b1}};

  typedef struct packed {
    logic [COORD_W-1:0]  coord_x;
    logic [COORD_W-1:0]  coord_y;
    logic [DEMAND_W-1:0] node_demand;
    logic                last_node;
  } in_req_t;

  typedef struct packed {
    logic [COST_W-1:0] total_cost;
    logic              overflow;
  } out_res_t;

  typedef struct packed {
    logic load;
    logic solve_init;
    logic dist_depot;
    logic d0_wr;
    logic pair_init;
    logic cap_i;
    logic next_i;
    logic skip_j;
    logic rd_cj;
    logic dist_pair;
    logic pair_wr;
    logic sel_init;
    logic scan;
    logic sel_take;
    logic lab_rd_j;
    logic cap_la;
    logic cap_lb;
    logic cap_ga;
    logic merge;
    logic sweep;
    logic finish;
  } srh_cmd_t;

  typedef struct packed {
    logic ci_end;
    logic cj_end;
    logic cj_eq_ci;
    logic dist_done;
    logic scan_end;
    logic found;
    logic flags_ok;
    logic same_group;
    logic fits;
    logic sweep_end;
  } srh_stat_t;
endpackage

// ----- rtl/savings_route_heuristic.sv -----
// Top level: savings route heuristic, controller plus datapath.
// Nodes load one per cycle while busy is low; the first node after reset or
// after a result is the depot. A request with last_node set starts the solve,
// and busy stays high until the cycle in which the one result is strobed on
// out_valid for a single cycle; the receiver cannot stall it. Depot distances and
// pair distances all go through the one bit-serial square root; each pick of the
// next largest saving is a full pass over the savings memory, and every accepted
// merge is checked and then relabels its group.
module savings_route_heuristic #(
  parameter int MAX_NODES  = srh_pkg::DEF_MAX_NODES,
  parameter int COORD_BITS = srh_pkg::DEF_COORD_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  srh_pkg::in_req_t  in_req,
  output logic              out_valid,
  output srh_pkg::out_res_t out_res,
  input  logic              cfg_we,
  input  logic [23:0]       cfg_wdata
);
  import srh_pkg::*;

`include "savings_route_heuristic_macros.svh"

  srh_cmd_t  cmd;
  srh_stat_t stat;

  srh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .last_node(in_req.last_node),
    .stat(stat), .cmd(cmd), .busy(busy));

  srh_datapath #(.MAX_NODES(MAX_NODES), .COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata), .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_res(out_res));

  `SRH_ASSERT_NEXT(a_solve_busy, start && !busy && in_req.last_node, busy)
  `SRH_ASSERT_NEXT(a_one_result, out_valid, !out_valid)
  `SRH_ASSERT_NOW(a_merge_fits, cmd.merge, stat.fits)
  `SRH_ASSERT_NEXT(a_finish_out, cmd.finish, out_valid && !busy)
endmodule

// ----- rtl/srh_ram.sv -----
// Generic one-write one-read RAM with registered read data.
module srh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ----- rtl/srh_isqrt.sv -----
// Bit-serial integer square root, one root bit per cycle.
module srh_isqrt #(
  parameter int RW = 17
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*RW-1:0] value,
  output logic            done,
  output logic [RW-1:0]   root
);
  localparam int CW = $clog2(RW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [RW:0]     rem_r;
  logic [RW-1:0]   q_r;
  logic [2*RW-1:0] v_r;
  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;
  logic [RW+1:0]   diff;
  logic            ge;

  assign rem_sh = {rem_r[RW-1:0], v_r[2*RW-1:2*RW-2]};
  assign trial  = {q_r, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RW);
        rem_r  <= '0;
        q_r    <= '0;
        v_r    <= value;
      end else if (busy_r) begin
        v_r <= {v_r[2*RW-3:0], 2'b00};
        if (ge) begin
          rem_r <= diff[RW:0];
          q_r   <= {q_r[RW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[RW:0];
          q_r   <= {q_r[RW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = q_r;
endmodule

// ----- rtl/srh_datapath.sv -----
// Datapath: node stores, distance unit, savings store, groups and cost.
module srh_datapath #(
  parameter int MAX_NODES  = 64,
  parameter int COORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  srh_pkg::in_req_t   in_req,
  input  logic               cfg_we,
  input  logic [23:0]        cfg_wdata,
  input  srh_pkg::srh_cmd_t  cmd,
  output srh_pkg::srh_stat_t stat,
  output logic               out_valid,
  output srh_pkg::out_res_t  out_res
);
  import srh_pkg::*;

  localparam int IW     = $clog2(MAX_NODES);
  localparam int NW     = $clog2(MAX_NODES + 1);
  localparam int CB     = COORD_BITS;
  localparam int DW     = CB + 1;
  localparam int SW     = DW + 1;
  localparam int KW     = SW + 2 * IW;
  localparam int GW     = DEMAND_W + IW;
  localparam int SDEPTH = MAX_NODES * MAX_NODES;
  localparam int SAW    = $clog2(SDEPTH);
  localparam int ACC_W  = DW + IW + 2;
  localparam int SAT_W  = ACC_W + COST_W;
  localparam int CMP_W  = (GW + 1 > CAP_W) ? GW + 1 : CAP_W;

  logic [CAP_W-1:0] cap_r;
  logic [NW-1:0]    cnt_r;
  logic             ovf_r;
  logic [CB-1:0]    dep_x_r, dep_y_r;
  logic [NW-1:0]    ci_r, cj_r;
  logic [CB-1:0]    xi_r, yi_r;
  logic [DW-1:0]    d0i_r, d0j_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [SAW:0]     wp_r, rp_r;
  logic             scan_pend_r, found_r, have_prev_r;
  logic [KW-1:0]    best_r, prev_r;
  logic [IW-1:0]    la_r, lb_r;
  logic [GW-1:0]    ga_r;
  logic [NW-1:0]    k_r;
  logic [IW-1:0]    kp_r;
  logic             spend_r;
  logic             out_valid_r;
  out_res_t         out_r;

  // distance unit
  logic [CB-1:0]   ax_r, ay_r, bx_r, by_r;
  logic [CB-1:0]   dx_r, dy_r;
  logic [2*CB-1:0] sx_r, sy_r;
  logic            go_r, v1_r, v2_r;
  logic            sq_done;
  logic [DW-1:0]   root;
  logic [2*DW-1:0] sq_val;

  logic [2*CB-1:0] xy_rdata;
  logic [DW-1:0]   d0_rdata;
  logic [GW-1:0]   gd_rdata;
  logic [IW-1:0]   lab_rdata;
  logic [KW-1:0]   sav_rdata;
  logic            sf_rdata, ef_rdata;

  logic            room;
  logic [IW-1:0]   rd_idx, bi, bj, lab_raddr, lab_waddr, lab_wdata, gd_raddr, gd_waddr;
  logic [IW-1:0]   sf_waddr, ef_waddr;
  logic            lab_we, gd_we, fl_we;
  logic [GW-1:0]   gd_wdata;
  logic [GW:0]     gsum;
  logic [DW+1:0]   sfull;
  logic            s_pos;
  logic [SW-1:0]   best_s;
  logic            eligible;
  logic signed [SAT_W-1:0] accw, lim;

  assign room   = cnt_r < NW'(MAX_NODES);
  assign rd_idx = cmd.rd_cj ? cj_r[IW-1:0] : ci_r[IW-1:0];
  assign bi     = best_r[2*IW-1:IW];
  assign bj     = best_r[IW-1:0];
  assign best_s = best_r[KW-1:2*IW];

  assign lab_raddr = cmd.sweep ? k_r[IW-1:0] : (cmd.lab_rd_j ? bj : bi);
  assign lab_we    = (cmd.load && room) || (spend_r && lab_rdata == lb_r);
  assign lab_waddr = cmd.load ? cnt_r[IW-1:0] : kp_r;
  assign lab_wdata = cmd.load ? cnt_r[IW-1:0] : la_r;

  // free start / free end flags: set as each node loads, cleared on merge
  assign fl_we    = (cmd.load && room) || cmd.merge;
  assign sf_waddr = cmd.load ? cnt_r[IW-1:0] : bi;
  assign ef_waddr = cmd.load ? cnt_r[IW-1:0] : bj;

  assign gsum     = (GW + 1)'(ga_r) + (GW + 1)'(gd_rdata);
  assign gd_raddr = cmd.cap_ga ? lb_r : la_r;
  assign gd_we    = (cmd.load && room) || cmd.merge;
  assign gd_waddr = cmd.load ? cnt_r[IW-1:0] : la_r;
  assign gd_wdata = cmd.load ? GW'(in_req.node_demand) : gsum[GW-1:0];

  assign sfull = (DW + 2)'(d0i_r) + (DW + 2)'(d0j_r) - (DW + 2)'(root);
  assign s_pos = !sfull[DW+1] && (sfull != '0);
  assign eligible = !have_prev_r || (sav_rdata < prev_r);
  assign sq_val = (2 * DW)'(sx_r) + (2 * DW)'(sy_r);

  srh_ram #(.WIDTH(2 * CB), .DEPTH(MAX_NODES)) u_xy (
    .clk(clk), .we(cmd.load && room), .waddr(cnt_r[IW-1:0]),
    .wdata({CB'(in_req.coord_x), CB'(in_req.coord_y)}),
    .raddr(rd_idx), .rdata(xy_rdata));

  srh_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_d0 (
    .clk(clk), .we(cmd.d0_wr), .waddr(ci_r[IW-1:0]), .wdata(root),
    .raddr(rd_idx), .rdata(d0_rdata));

  srh_ram #(.WIDTH(GW), .DEPTH(MAX_NODES)) u_gd (
    .clk(clk), .we(gd_we), .waddr(gd_waddr), .wdata(gd_wdata),
    .raddr(gd_raddr), .rdata(gd_rdata));

  srh_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_lab (
    .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
    .raddr(lab_raddr), .rdata(lab_rdata));

  srh_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_sf (
    .clk(clk), .we(fl_we), .waddr(sf_waddr), .wdata(cmd.load),
    .raddr(bi), .rdata(sf_rdata));

  srh_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_ef (
    .clk(clk), .we(fl_we), .waddr(ef_waddr), .wdata(cmd.load),
    .raddr(bj), .rdata(ef_rdata));

  srh_ram #(.WIDTH(KW), .DEPTH(SDEPTH)) u_sav (
    .clk(clk), .we(cmd.pair_wr && s_pos), .waddr(wp_r[SAW-1:0]),
    .wdata({sfull[SW-1:0], ci_r[IW-1:0], cj_r[IW-1:0]}),
    .raddr(rp_r[SAW-1:0]), .rdata(sav_rdata));

  srh_isqrt #(.RW(DW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(v2_r), .value(sq_val),
    .done(sq_done), .root(root));

  always_ff @(posedge clk) begin
    dx_r <= (ax_r > bx_r) ? ax_r - bx_r : bx_r - ax_r;
    dy_r <= (ay_r > by_r) ? ay_r - by_r : by_r - ay_r;
    sx_r <= dx_r * dx_r;
    sy_r <= dy_r * dy_r;
    if (cmd.dist_depot) begin
      ax_r <= dep_x_r;
      ay_r <= dep_y_r;
    end else if (cmd.dist_pair) begin
      ax_r <= xi_r;
      ay_r <= yi_r;
    end
    if (cmd.dist_depot || cmd.dist_pair) begin
      bx_r <= xy_rdata[2*CB-1:CB];
      by_r <= xy_rdata[CB-1:0];
    end
    if (cmd.dist_pair) d0j_r <= d0_rdata;
    if (cmd.load && cnt_r == '0) begin
      dep_x_r <= CB'(in_req.coord_x);
      dep_y_r <= CB'(in_req.coord_y);
    end
    if (cmd.cap_i) begin
      xi_r  <= xy_rdata[2*CB-1:CB];
      yi_r  <= xy_rdata[CB-1:0];
      d0i_r <= d0_rdata;
    end
    if (cmd.cap_la) la_r <= lab_rdata;
    if (cmd.cap_lb) lb_r <= lab_rdata;
    if (cmd.cap_ga) ga_r <= gd_rdata;
    if (cmd.sweep) kp_r <= k_r[IW-1:0];
    if (cmd.sel_take) prev_r <= best_r;
    if (scan_pend_r && eligible && (!found_r || sav_rdata > best_r)) best_r <= sav_rdata;
  end

  always_comb begin
    accw = SAT_W'(acc_r);
    lim  = SAT_W'({1'b0, COST_MAX});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      go_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      scan_pend_r <= 1'b0;
      spend_r     <= 1'b0;
      found_r     <= 1'b0;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      go_r        <= cmd.dist_depot || cmd.dist_pair;
      v1_r        <= go_r;
      v2_r        <= v1_r;
      out_valid_r <= cmd.finish;
      scan_pend_r <= cmd.scan && (rp_r < wp_r);
      spend_r     <= cmd.sweep && (k_r < cnt_r);
      if (cmd.load) begin
        if (room) cnt_r <= cnt_r + 1'b1;
        else ovf_r <= 1'b1;
      end
      if (cmd.solve_init) begin
        ci_r        <= NW'(1);
        acc_r       <= '0;
        wp_r        <= '0;
        have_prev_r <= 1'b0;
      end
      if (cmd.d0_wr) begin
        ci_r  <= ci_r + 1'b1;
        acc_r <= acc_r + ACC_W'({root, 1'b0});
      end
      if (cmd.pair_init) ci_r <= NW'(1);
      if (cmd.cap_i) cj_r <= NW'(1);
      if (cmd.next_i) ci_r <= ci_r + 1'b1;
      if (cmd.skip_j || cmd.pair_wr) cj_r <= cj_r + 1'b1;
      if (cmd.pair_wr && s_pos) wp_r <= wp_r + 1'b1;
      if (cmd.sel_init) begin
        rp_r    <= '0;
        found_r <= 1'b0;
      end
      if (cmd.scan && rp_r < wp_r) rp_r <= rp_r + 1'b1;
      if (scan_pend_r && eligible) found_r <= 1'b1;
      if (cmd.sel_take) have_prev_r <= 1'b1;
      if (cmd.merge) begin
        acc_r <= acc_r - ACC_W'(best_s);
        k_r   <= '0;
      end
      if (cmd.sweep && k_r < cnt_r) k_r <= k_r + 1'b1;
      if (cmd.finish) begin
        out_r.overflow <= ovf_r;
        if (accw < 0) out_r.total_cost <= '0;
        else if (accw > lim) out_r.total_cost <= COST_MAX;
        else out_r.total_cost <= accw[COST_W-1:0];
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.ci_end     = ci_r >= cnt_r;
    stat.cj_end     = cj_r >= cnt_r;
    stat.cj_eq_ci   = cj_r == ci_r;
    stat.dist_done  = sq_done;
    stat.scan_end   = rp_r >= wp_r;
    stat.found      = found_r;
    stat.flags_ok   = sf_rdata && ef_rdata;
    stat.same_group = lab_rdata == la_r;
    stat.fits       = CMP_W'(gsum) <= CMP_W'(cap_r);
    stat.sweep_end  = k_r >= cnt_r;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;
endmodule

// ----- rtl/srh_ctrl.sv -----
// Controller: sequences load, distance, savings, selection and merge steps.
module srh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               last_node,
  input  srh_pkg::srh_stat_t stat,
  output srh_pkg::srh_cmd_t  cmd,
  output logic               busy
);
  import srh_pkg::*;

  typedef enum logic [4:0] {
    IDLE, D0_RD, D0_WAIT, D0_DIST, PR_I, PR_IW, PR_J, PR_JW, PR_DIST,
    SEL_INIT, SEL_SCAN, SEL_LAST, SEL_EVAL, M_LA, M_LB, M_GA, M_GB,
    M_SWEEP, M_SWEND, FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_node) begin
            cmd.solve_init = 1'b1;
            state_nxt      = D0_RD;
          end
        end
      end
      D0_RD: begin
        if (stat.ci_end) begin
          cmd.pair_init = 1'b1;
          state_nxt     = PR_I;
        end else begin
          state_nxt = D0_WAIT;
        end
      end
      D0_WAIT: begin
        cmd.dist_depot = 1'b1;
        state_nxt      = D0_DIST;
      end
      D0_DIST: begin
        if (stat.dist_done) begin
          cmd.d0_wr = 1'b1;
          state_nxt = D0_RD;
        end
      end
      PR_I: state_nxt = stat.ci_end ? SEL_INIT : PR_IW;
      PR_IW: begin
        cmd.cap_i = 1'b1;
        state_nxt = PR_J;
      end
      PR_J: begin
        if (stat.cj_end) begin
          cmd.next_i = 1'b1;
          state_nxt  = PR_I;
        end else if (stat.cj_eq_ci) begin
          cmd.skip_j = 1'b1;
        end else begin
          cmd.rd_cj = 1'b1;
          state_nxt = PR_JW;
        end
      end
      PR_JW: begin
        cmd.rd_cj     = 1'b1;
        cmd.dist_pair = 1'b1;
        state_nxt     = PR_DIST;
      end
      PR_DIST: begin
        if (stat.dist_done) begin
          cmd.pair_wr = 1'b1;
          state_nxt   = PR_J;
        end
      end
      SEL_INIT: begin
        cmd.sel_init = 1'b1;
        state_nxt    = SEL_SCAN;
      end
      SEL_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) state_nxt = SEL_LAST;
      end
      SEL_LAST: state_nxt = SEL_EVAL;
      SEL_EVAL: begin
        if (!stat.found) begin
          state_nxt = FINISH;
        end else begin
          cmd.sel_take = 1'b1;
          state_nxt    = stat.flags_ok ? M_LA : SEL_INIT;
        end
      end
      M_LA: begin
        cmd.cap_la   = 1'b1;
        cmd.lab_rd_j = 1'b1;
        state_nxt    = M_LB;
      end
      M_LB: begin
        cmd.cap_lb = 1'b1;
        state_nxt  = stat.same_group ? SEL_INIT : M_GA;
      end
      M_GA: begin
        cmd.cap_ga = 1'b1;
        state_nxt  = M_GB;
      end
      M_GB: begin
        if (stat.fits) begin
          cmd.merge = 1'b1;
          state_nxt = M_SWEEP;
        end else begin
          state_nxt = SEL_INIT;
        end
      end
      M_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_end) state_nxt = M_SWEND;
      end
      M_SWEND: state_nxt = SEL_INIT;
      FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = IDLE;
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= state_nxt != IDLE;
    end
  end

  assign busy = busy_r;
endmodule
